@@ rtl/m2i_pkg.sv @@
`default_nettype none
package m2i_pkg;

	localparam int ElemW    = 16;
	localparam int AdjW     = ElemW + 1;
	localparam int DetW     = 32;
	localparam int TolW     = 31;
	localparam int QW       = 16;
	localparam int NumW     = DetW + 2;
	localparam int DenW     = DetW + 1;
	localparam int CmpW     = DenW + QW;
	localparam int DivSteps = QW;
	localparam int NumLanes = 4;
	localparam int AddrW    = 3;
	localparam int DataW    = 32;

	// Register index, taken from paddr above the byte offset.
	localparam logic RegIdxTol = 1'b0;
	localparam logic [TolW-1:0] TolReset = TolW'(1);

	typedef logic signed [ElemW-1:0] m2i_elem_t;

	typedef struct packed {
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
		logic            neg;
	} m2i_lane_in_t;

	typedef struct packed {
		logic [QW-1:0] q;
		logic          big;
		logic          neg;
	} m2i_lane_res_t;

endpackage
`default_nettype wire

@@ rtl/m2i_if.sv @@
`default_nettype none
interface m2i_in_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] m_r0c0;
	logic signed [15:0] m_r0c1;
	logic signed [15:0] m_r1c0;
	logic signed [15:0] m_r1c1;

	modport source (output valid, m_r0c0, m_r0c1, m_r1c0, m_r1c1, input ready);
	modport sink (input valid, m_r0c0, m_r0c1, m_r1c0, m_r1c1, output ready);
endinterface

interface m2i_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] inv_r0c0;
	logic signed [15:0] inv_r0c1;
	logic signed [15:0] inv_r1c0;
	logic signed [15:0] inv_r1c1;
	logic signed [31:0] determinant;
	logic               singular;
	logic               saturated;

	modport source (output valid, inv_r0c0, inv_r0c1, inv_r1c0, inv_r1c1, determinant,
		singular, saturated, input ready);
	modport sink (input valid, inv_r0c0, inv_r0c1, inv_r1c0, inv_r1c1, determinant,
		singular, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/m2i_lane.sv @@
`default_nettype none
// One divider lane: an overflow check stage followed by one restoring
// step per quotient bit, most significant bit first.
module m2i_lane import m2i_pkg::*; (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire m2i_lane_in_t  din,
	output m2i_lane_res_t      dout
);

	logic [NumW-1:0] num_s [0:DivSteps];
	logic [DenW-1:0] den_s [0:DivSteps];
	logic [QW-1:0]   q_s   [0:DivSteps];
	logic            neg_s [0:DivSteps];
	logic            big_s [0:DivSteps];

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= din.num;
			den_s[0] <= din.den;
			neg_s[0] <= din.neg;
			q_s[0]   <= '0;
			// Quotient of 2^16 or more always saturates.
			big_s[0] <= CmpW'(din.num) >= {din.den, {QW{1'b0}}};
		end
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		localparam int Bit = DivSteps - 1 - k;
		logic [CmpW-1:0] dsh;
		logic            ge;
		logic [QW-1:0]   qn;

		always_comb begin
			dsh   = CmpW'(den_s[k]) << Bit;
			ge    = CmpW'(num_s[k]) >= dsh;
			qn    = q_s[k];
			qn[Bit] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= ge ? num_s[k] - dsh[NumW-1:0] : num_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= qn;
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
			end
		end
	end

	assign dout = '{q: q_s[DivSteps], big: big_s[DivSteps], neg: neg_s[DivSteps]};

endmodule
`default_nettype wire

@@ rtl/m2i_merge.sv @@
`default_nettype none
// Applies sign and saturation to each lane, or gives zero for a singular matrix, and merges the clip flags.
module m2i_merge import m2i_pkg::*; (
	input  wire m2i_lane_res_t res [NumLanes],
	input  wire logic          sing,
	output m2i_elem_t          inv [NumLanes],
	output logic               sat
);

	logic [NumLanes-1:0] clip;

	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			clip[i] = 1'b0;
			inv[i]  = '0;
			if (!sing) begin
				if (res[i].neg) begin
					if (res[i].big || res[i].q > QW'(32768)) begin
						clip[i] = 1'b1;
						inv[i]  = m2i_elem_t'(-32768);
					end else begin
						inv[i] = m2i_elem_t'(-res[i].q);
					end
				end else begin
					if (res[i].big || res[i].q > QW'(32767)) begin
						clip[i] = 1'b1;
						inv[i]  = m2i_elem_t'(32767);
					end else begin
						inv[i] = m2i_elem_t'(res[i].q);
					end
				end
			end
		end
		sat = |clip;
	end

endmodule
`default_nettype wire

@@ rtl/matrix2x2_inverse.sv @@
`default_nettype none
// An accepted item passes through 21 register stages before its result can be taken from
// the output channel.
// Throughput: one item per cycle unless stalled; the four divider lanes are fully pipelined,
// one restoring quotient bit per stage, and the 16 quotient bits set the depth.
// The pipeline stalls as a whole only while the output register is held.
// Reset (arst_n low, asynchronous) empties the pipeline and sets the
// singular tolerance register to 1.
module matrix2x2_inverse import m2i_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	m2i_in_if.sink                in_ch,
	m2i_out_if.source             out_ch,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic [DataW-1:0]      prdata,
	output logic                  pready
);

	localparam int LaneDepth = DivSteps + 1;

	// Configuration register. Address bit 2 selects the register index;
	// only index zero exists, so other writes are dropped.
	logic [TolW-1:0] tol_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxTol);
	assign prdata = (paddr[2] == RegIdxTol) ? DataW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TolReset;
		end else if (cfg_wr) begin
			tol_q <= pwdata[TolW-1:0];
		end
	end

	// The whole pipeline advances together whenever the output register
	// is empty or being drained, so a new valid item is accepted in every such cycle.
	logic out_valid_q;
	logic en;

	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	logic                v_s1, v_s2, v_s3;
	logic [LaneDepth-1:0] lvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			lvld_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_ch.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			lvld_q      <= {lvld_q[LaneDepth-2:0], v_s3};
			out_valid_q <= lvld_q[LaneDepth-1];
		end
	end

	// Stage 1: the two products of the determinant.
	m2i_elem_t          a_s1, b_s1, c_s1, d_s1;
	logic signed [DetW-1:0] pad_s1, pbc_s1;

	// Stage 2: the determinant itself, which always fits in 32 bits.
	m2i_elem_t          a_s2, b_s2, c_s2, d_s2;
	logic signed [DetW-1:0] det_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= in_ch.m_r0c0;
			b_s1   <= in_ch.m_r0c1;
			c_s1   <= in_ch.m_r1c0;
			d_s1   <= in_ch.m_r1c1;
			pad_s1 <= DetW'(in_ch.m_r0c0 * in_ch.m_r1c1);
			pbc_s1 <= DetW'(in_ch.m_r0c1 * in_ch.m_r1c0);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			d_s2   <= d_s1;
			det_s2 <= pad_s1 - pbc_s1;
		end
	end

	// Stage 3: magnitude, singular test and the per-lane numerator
	// 2*|adj|*65536 + |det| over denominator 2*|det|, which gives a quotient
	// rounded to nearest with ties away from zero.
	logic [DetW-1:0]        mag;
	logic                   sing;
	logic signed [AdjW-1:0] adj    [NumLanes];
	logic [AdjW-1:0]        absadj [NumLanes];
	m2i_lane_in_t           lin    [NumLanes];

	always_comb begin
		mag    = det_s2[DetW-1] ? DetW'(-det_s2) : DetW'(det_s2);
		sing   = (mag < DetW'(tol_q)) || (det_s2 == '0);
		adj[0] = AdjW'(d_s2);
		adj[1] = -AdjW'(b_s2);
		adj[2] = -AdjW'(c_s2);
		adj[3] = AdjW'(a_s2);
		for (int i = 0; i < NumLanes; i++) begin
			absadj[i]  = adj[i][AdjW-1] ? AdjW'(-adj[i]) : AdjW'(adj[i]);
			lin[i].num = NumW'({absadj[i], {(QW+1){1'b0}}}) + NumW'(mag);
			lin[i].den = {mag, 1'b0};
			lin[i].neg = adj[i][AdjW-1] ^ det_s2[DetW-1];
		end
	end

	m2i_lane_in_t          lin_s3 [NumLanes];
	logic signed [DetW-1:0] det_s3;
	logic                  sing_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s3  <= lin;
			det_s3  <= det_s2;
			sing_s3 <= sing;
		end
	end

	// Divider lanes, one per inverse element.
	m2i_lane_res_t lres [NumLanes];

	for (genvar i = 0; i < NumLanes; i++) begin : g_lane
		m2i_lane u_lane (
			.clk  (clk),
			.en   (en),
			.din  (lin_s3[i]),
			.dout (lres[i])
		);
	end

	// Determinant and singular flag travel alongside the lanes.
	logic signed [DetW-1:0] ldet_q  [LaneDepth];
	logic [LaneDepth-1:0]   lsing_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ldet_q[0] <= det_s3;
			for (int k = 1; k < LaneDepth; k++) begin
				ldet_q[k] <= ldet_q[k-1];
			end
			lsing_q <= {lsing_q[LaneDepth-2:0], sing_s3};
		end
	end

	// Merge stage and output register.
	m2i_elem_t inv [NumLanes];
	logic      sat;

	m2i_merge u_merge (
		.res  (lres),
		.sing (lsing_q[LaneDepth-1]),
		.inv  (inv),
		.sat  (sat)
	);

	m2i_elem_t              inv_q [NumLanes];
	logic signed [DetW-1:0] det_q;
	logic                   sing_q;
	logic                   sat_q;

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q  <= inv;
			det_q  <= ldet_q[LaneDepth-1];
			sing_q <= lsing_q[LaneDepth-1];
			sat_q  <= sat;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.inv_r0c0    = inv_q[0];
	assign out_ch.inv_r0c1    = inv_q[1];
	assign out_ch.inv_r1c0    = inv_q[2];
	assign out_ch.inv_r1c1    = inv_q[3];
	assign out_ch.determinant = det_q;
	assign out_ch.singular    = sing_q;
	assign out_ch.saturated   = sat_q;

`ifndef ASSERT_OFF
	// A singular result carries a zero inverse and no clip flag.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sing_q |-> !sat_q && inv_q[0] == '0 && inv_q[1] == '0
			&& inv_q[2] == '0 && inv_q[3] == '0)
		else $error("singular result with nonzero inverse");

	// While stalled, the valid bits v_s3, the lane valid chain and the output valid hold.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(lvld_q) && $stable(v_s3) && $stable(out_valid_q))
		else $error("pipeline moved while stalled");

	// A write to the tolerance register index lands in the tolerance register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> tol_q == $past(pwdata[TolW-1:0]))
		else $error("tolerance write lost");
`endif

endmodule
`default_nettype wire
